// ----- hdl/ial_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ial_pkg: shared types and constants for the indexed array list
// Sizing, opcode and status codes, and the command that is broadcast to the
// row of slot cells.
// ----------------------------------------------------------------------------
package ial_pkg;

  localparam int DEPTH   = 128;
  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int POS_W   = 8;
  localparam int LEN_W   = 8;
  localparam int ST_W    = 2;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Packed stream words, padded to whole bytes
  localparam int IN_W    = ((OP_W + POS_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_W   = ((DATA_W + LEN_W + ST_W + 7) / 8) * 8;
  localparam int IN_POS_LO = OP_W;
  localparam int IN_VAL_LO = OP_W + POS_W;
  localparam int OUT_LEN_LO = DATA_W;
  localparam int OUT_ST_LO  = DATA_W + LEN_W;

  // Read-back OR tree: fan-in of 8 per registered level
  localparam int TREE_FAN_LG = 3;
  localparam int TREE_FAN    = 1 << TREE_FAN_LG;
  localparam int TREE_LVLS   = (IDX_W + TREE_FAN_LG - 1) / TREE_FAN_LG;
  localparam int TREE_LEAVES = 1 << (TREE_FAN_LG * TREE_LVLS);
  localparam int WAIT_W      = $clog2(TREE_LVLS + 2);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_APPEND   = 3'd1,
    OP_DELETE   = 3'd2,
    OP_DEL_LAST = 3'd3,
    OP_READ     = 3'd4,
    OP_REPLACE  = 3'd5,
    OP_CLEAR    = 3'd6
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_POS   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic              shift_up;  // slots above pos take their lower neighbor
    logic              shift_dn;  // slots at and above pos take their upper neighbor
    logic              wr;        // slot at pos takes value
    logic              rd;        // slot at pos drives its entry into the read tree
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ----- hdl/ial_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ial_cell: one list slot
// Holds one entry, shifts to or from its neighbors, takes a write and
// presents its old entry to the read tree when addressed.
// ----------------------------------------------------------------------------
module ial_cell (
  input  logic                      clk,
  input  logic [ial_pkg::IDX_W-1:0]  idx_i,
  input  ial_pkg::cell_cmd_t        cmd_i,
  input  logic [ial_pkg::DATA_W-1:0] left_i,
  input  logic [ial_pkg::DATA_W-1:0] right_i,
  output logic [ial_pkg::DATA_W-1:0] entry_o,
  output logic [ial_pkg::DATA_W-1:0] tap_o
);
  import ial_pkg::*;

  logic [DATA_W-1:0] entry_r, entry_nxt;
  logic [DATA_W-1:0] tap_r, tap_nxt;
  logic              hit;
  logic              above;

  assign hit   = (idx_i == cmd_i.pos);
  assign above = (idx_i > cmd_i.pos);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd_i.shift_up && above) begin
      entry_nxt = left_i;
    end
    if (cmd_i.wr && hit) begin
      entry_nxt = cmd_i.value;
    end
    if (cmd_i.shift_dn && (above || hit)) begin
      entry_nxt = right_i;
    end
    // sample the entry before this cycle's move
    tap_nxt = (cmd_i.rd && hit) ? entry_r : '0;
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    tap_r   <= tap_nxt;
  end

  assign entry_o = entry_r;
  assign tap_o   = tap_r;

endmodule

// ----- hdl/ial_or_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ial_or_tree: registered read-back tree
// ORs the cell taps together, eight per node and one register per level;
// at most one tap is nonzero, so the root carries the addressed entry.
// ----------------------------------------------------------------------------
module ial_or_tree (
  input  logic                      clk,
  input  logic [ial_pkg::DATA_W-1:0] taps_i [ial_pkg::DEPTH],
  output logic [ial_pkg::DATA_W-1:0] root_o
);
  import ial_pkg::*;

  logic [DATA_W-1:0] node [TREE_LVLS+1][TREE_LEAVES];
  logic [DATA_W-1:0] grp_w [TREE_LVLS+1][TREE_LEAVES];

  genvar l, n;
  generate
    for (n = 0; n < TREE_LEAVES; n++) begin : g_leaf
      if (n < DEPTH) begin : g_tap
        assign node[0][n] = taps_i[n];
      end else begin : g_pad
        assign node[0][n] = '0;
      end
    end

    for (l = 1; l <= TREE_LVLS; l++) begin : g_lvl
      for (n = 0; n < (TREE_LEAVES >> (TREE_FAN_LG * l)); n++) begin : g_node
        always_comb begin
          grp_w[l][n] = '0;
          for (int k = 0; k < TREE_FAN; k++) begin
            grp_w[l][n] = grp_w[l][n] | node[l-1][n*TREE_FAN + k];
          end
        end

        always_ff @(posedge clk) begin
          node[l][n] <= grp_w[l][n];
        end
      end
    end
  endgenerate

  assign root_o = node[TREE_LVLS][0];

endmodule

// ----- hdl/indexed_array_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_list: ordered list with insert/delete at an index
// A row of DEPTH slot cells shifts all entries in parallel; reads return
// through a registered OR tree.
// ----------------------------------------------------------------------------
// Pipeline: a result is registered by the decode stage, then by the cell tap,
//   then by each level of the read tree, and is then captured in the output
//   register. Flow: one transaction in flight; the next is accepted at the
//   earliest in the cycle after the result is taken.
// Reset: rst_n clears the length and the control; entries stay as they are.
module indexed_array_list (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [ial_pkg::IN_W-1:0]  in_tdata,   // opcode[2:0], position[10:3], value[42:11]
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [ial_pkg::OUT_W-1:0] out_tdata   // read_value[31:0], length[39:32], status[41:40]
);
  import ial_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  cell_cmd_t          cmd_r, cmd_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [WAIT_W-1:0]  wait_r, wait_nxt;
  status_t            st_r, st_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [DATA_W-1:0]  rv_r, rv_nxt;

  opcode_t            in_op;
  logic [POS_W-1:0]   in_position;
  logic [DATA_W-1:0]  in_value;
  logic [CMP_W-1:0]   pos_ext, cnt_ext;
  logic               is_full, cnt_zero, pos_lt, pos_le;
  logic               in_acc;

  cell_cmd_t          dec_cmd;
  status_t            dec_st;
  logic [CNT_W-1:0]   dec_cnt;

  logic [DATA_W-1:0]  ent_w [DEPTH];
  logic [DATA_W-1:0]  tap_w [DEPTH];
  logic [DATA_W-1:0]  root_w;

  assign in_op       = opcode_t'(in_tdata[OP_W-1:0]);
  assign in_position = in_tdata[IN_POS_LO +: POS_W];
  assign in_value    = in_tdata[IN_VAL_LO +: DATA_W];

  assign pos_ext  = CMP_W'(in_position);
  assign cnt_ext  = CMP_W'(count_r);
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign cnt_zero = (count_r == '0);
  assign pos_lt   = (pos_ext < cnt_ext);
  assign pos_le   = (pos_ext <= cnt_ext);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // decode against the current length
  always_comb begin
    dec_cmd       = '0;
    dec_cmd.pos   = IDX_W'(in_position);
    dec_cmd.value = in_value;
    dec_st        = ST_OK;
    dec_cnt       = count_r;
    case (in_op)
      OP_INSERT: begin
        if (is_full) begin
          dec_st = ST_FULL;
        end else if (!pos_le) begin
          dec_st = ST_POS;
        end else begin
          dec_cmd.shift_up = 1'b1;
          dec_cmd.wr       = 1'b1;
          dec_cnt          = CNT_W'(count_r + 1'b1);
        end
      end
      OP_APPEND: begin
        if (is_full) begin
          dec_st = ST_FULL;
        end else begin
          dec_cmd.pos      = IDX_W'(count_r);
          dec_cmd.shift_up = 1'b1;
          dec_cmd.wr       = 1'b1;
          dec_cnt          = CNT_W'(count_r + 1'b1);
        end
      end
      OP_DELETE: begin
        if (cnt_zero) begin
          dec_st = ST_EMPTY;
        end else if (!pos_lt) begin
          dec_st = ST_POS;
        end else begin
          dec_cmd.shift_dn = 1'b1;
          dec_cmd.rd       = 1'b1;
          dec_cnt          = CNT_W'(count_r - 1'b1);
        end
      end
      OP_DEL_LAST: begin
        if (cnt_zero) begin
          dec_st = ST_EMPTY;
        end else begin
          dec_cmd.pos = IDX_W'(count_r - 1'b1);
          dec_cmd.rd  = 1'b1;
          dec_cnt     = CNT_W'(count_r - 1'b1);
        end
      end
      OP_READ: begin
        if (cnt_zero) begin
          dec_st = ST_EMPTY;
        end else if (!pos_lt) begin
          dec_st = ST_POS;
        end else begin
          dec_cmd.rd = 1'b1;
        end
      end
      OP_REPLACE: begin
        if (cnt_zero) begin
          dec_st = ST_EMPTY;
        end else if (!pos_lt) begin
          dec_st = ST_POS;
        end else begin
          dec_cmd.wr = 1'b1;
        end
      end
      OP_CLEAR: begin
        dec_cnt = '0;
      end
      default: begin
        dec_st = ST_POS;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = '0;        // command lives for one cycle only
    count_nxt = count_r;
    wait_nxt  = wait_r;
    st_nxt    = st_r;
    len_nxt   = len_r;
    rv_nxt    = rv_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = dec_cmd;
          count_nxt = dec_cnt;
          st_nxt    = dec_st;
          len_nxt   = LEN_W'(dec_cnt);
          wait_nxt  = WAIT_W'(TREE_LVLS + 1);
          state_nxt = S_BUSY;
        end
      end
      S_BUSY: begin
        if (wait_r == '0) begin
          rv_nxt    = root_w;
          state_nxt = S_OUT;
        end else begin
          wait_nxt = WAIT_W'(wait_r - 1'b1);
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= '0;
      count_r <= '0;
      wait_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      count_r <= count_nxt;
      wait_r  <= wait_nxt;
      st_r    <= st_nxt;
      len_r   <= len_nxt;
      rv_r    <= rv_nxt;
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_W-1:0] left_w, right_w;
      if (g == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = ent_w[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_w = ent_w[g];
      end else begin : g_mid_r
        assign right_w = ent_w[g+1];
      end

      ial_cell u_cell (
        .clk     (clk),
        .idx_i   (IDX_W'(g)),
        .cmd_i   (cmd_r),
        .left_i  (left_w),
        .right_i (right_w),
        .entry_o (ent_w[g]),
        .tap_o   (tap_w[g])
      );
    end
  endgenerate

  ial_or_tree u_tree (
    .clk    (clk),
    .taps_i (tap_w),
    .root_o (root_w)
  );

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {(OUT_W - DATA_W - LEN_W - ST_W)'(0), st_r, len_r, rv_r};

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the indexed array list
// Streams list commands (insert, append, delete, read, replace, clear and the
// unused opcode) into the block, keeps its own copy of the list to predict
// every result, and checks each returned transaction field by field while
// both stream sides idle and stall in phases.
// ----------------------------------------------------------------------------
module testbench;
  import ial_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  localparam int TOTAL_CMDS   = 1325;
  localparam int DRAIN_CYCLES = 4 * (TREE_LVLS + 2);
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_CMDS   = 64;

  localparam logic [OP_W-1:0]   OP_UNUSED = 3'd7;
  localparam logic [DATA_W-1:0] VAL_MIN   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX   = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] VAL_ONES  = 32'hffff_ffff;

  typedef enum int {
    BURST_GROW,
    BURST_SHRINK,
    BURST_MIXED,
    BURST_NOISE,
    BURST_FILL
  } burst_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    int                gap_pct;
    int                stall_pct;
  } list_cmd_t;

  typedef struct {
    logic [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]  length;
    status_t           status;
  } list_rsp_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  list_cmd_t   cmd_queue[$];
  list_rsp_t   predicted_rsp[$];
  list_cmd_t   cmd_on_bus;
  int          rx_stall_pct = 0;
  int          mismatch_count = 0;
  int          rsp_count = 0;
  int          cycle_count = 0;
  int          queued_count = 0;
  int          gen_len = 0;

  // Shadow copy of the list
  logic [DATA_W-1:0] list_entries [DEPTH];
  int                list_len = 0;

  indexed_array_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Apply one command to the shadow list and return the result it causes
  function automatic list_rsp_t apply_list_op(list_cmd_t cmd);
    list_rsp_t rsp;
    int        p;
    rsp.read_value = '0;
    rsp.status     = ST_OK;
    p = int'(cmd.pos);
    case (cmd.op)
      OP_INSERT: begin
        if (list_len >= DEPTH) begin
          rsp.status = ST_FULL;
        end else if (p > list_len) begin
          rsp.status = ST_POS;
        end else begin
          for (int i = list_len; i > p; i--) list_entries[i] = list_entries[i-1];
          list_entries[p] = cmd.value;
          list_len++;
        end
      end
      OP_APPEND: begin
        if (list_len >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          list_entries[list_len] = cmd.value;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          rsp.status = ST_EMPTY;
        end else if (p >= list_len) begin
          rsp.status = ST_POS;
        end else begin
          rsp.read_value = list_entries[p];
          for (int i = p; i + 1 < list_len; i++) list_entries[i] = list_entries[i+1];
          list_len--;
        end
      end
      OP_DEL_LAST: begin
        if (list_len == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.read_value = list_entries[list_len-1];
          list_len--;
        end
      end
      OP_READ: begin
        if (list_len == 0) rsp.status = ST_EMPTY;
        else if (p >= list_len) rsp.status = ST_POS;
        else rsp.read_value = list_entries[p];
      end
      OP_REPLACE: begin
        if (list_len == 0) rsp.status = ST_EMPTY;
        else if (p >= list_len) rsp.status = ST_POS;
        else list_entries[p] = cmd.value;
      end
      OP_CLEAR: begin
        list_len = 0;
      end
      default: begin
        rsp.status = ST_POS;
      end
    endcase
    rsp.length = LEN_W'(list_len);
    return rsp;
  endfunction

  // Length only, to steer the generator toward deep states
  function automatic int len_after(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, int len);
    case (op)
      OP_INSERT:   return (len < DEPTH && pos <= len) ? len + 1 : len;
      OP_APPEND:   return (len < DEPTH) ? len + 1 : len;
      OP_DELETE:   return (len > 0 && pos < len) ? len - 1 : len;
      OP_DEL_LAST: return (len > 0) ? len - 1 : len;
      OP_CLEAR:    return 0;
      default:     return len;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(int span);
    int r;
    r = $urandom_range(99);
    if (r < 8) return POS_W'($urandom_range(0, 255));
    if (r < 16 || span == 0) return POS_W'(span + $urandom_range(0, 1));
    return POS_W'($urandom_range(0, span - 1));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return VAL_ONES;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_cmd(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                          logic [DATA_W-1:0] value);
    list_cmd_t cmd;
    cmd.op    = op;
    cmd.pos   = pos;
    cmd.value = value;
    // Idle phases rotate: none, sender gaps, receiver stalls, both
    case ((queued_count / PHASE_CMDS) % 4)
      0: begin cmd.gap_pct = 0;  cmd.stall_pct = 0;  end
      1: begin cmd.gap_pct = 51; cmd.stall_pct = 0;  end
      2: begin cmd.gap_pct = 0;  cmd.stall_pct = 51; end
      default: begin cmd.gap_pct = 12; cmd.stall_pct = 12; end
    endcase
    cmd_queue.push_back(cmd);
    gen_len = len_after(op, pos, gen_len);
    queued_count++;
  endtask

  // Driver: present queued commands, hold each until it is taken
  always @(posedge clk) begin
    list_cmd_t cmd;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predicted_rsp.push_back(apply_list_op(cmd_on_bus));
      if (!in_tvalid || in_tready) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= cmd_queue[0].gap_pct) begin
          cmd = cmd_queue.pop_front();
          cmd_on_bus = cmd;
          in_tdata     <= IN_W'({cmd.value, cmd.pos, cmd.op});
          in_tvalid    <= 1'b1;
          rx_stall_pct <= cmd.stall_pct;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest prediction
  always @(posedge clk) begin
    list_rsp_t got;
    list_rsp_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.read_value = out_tdata[DATA_W-1:0];
        got.length     = out_tdata[OUT_LEN_LO +: LEN_W];
        got.status     = status_t'(out_tdata[OUT_ST_LO +: ST_W]);
        if (predicted_rsp.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("[%0t] result %0d with nothing expected: value %h length %0d status %0d",
                     $realtime, rsp_count, got.read_value, got.length, got.status);
          mismatch_count++;
        end else begin
          want = predicted_rsp.pop_front();
          if (got.read_value !== want.read_value || got.length !== want.length ||
              got.status !== want.status) begin
            if (mismatch_count < MAX_REPORTS)
              $display({"[%0t] result %0d mismatch: value %h/%h length %0d/%0d ",
                        "status %0d/%0d (expected/actual)"}, $realtime, rsp_count,
                       want.read_value, got.read_value, want.length, got.length,
                       want.status, got.status);
            mismatch_count++;
          end
        end
        rsp_count++;
      end
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    burst_t            kind;
    int                burst_idx;
    int                burst_len;
    int                r;
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;

    // Errors on an empty list, then edges of a small list
    push_cmd(OP_DEL_LAST, 8'd0, '0);
    push_cmd(OP_DELETE, 8'd0, '0);
    push_cmd(OP_READ, 8'd0, '0);
    push_cmd(OP_REPLACE, 8'd0, VAL_ONES);
    push_cmd(OP_INSERT, 8'd1, VAL_MAX);
    push_cmd(OP_INSERT, 8'd0, VAL_MIN);
    push_cmd(OP_APPEND, 8'd255, VAL_MAX);
    push_cmd(OP_INSERT, 8'd2, VAL_ONES);  // position equal to length appends
    push_cmd(OP_INSERT, 8'd1, '0);
    push_cmd(OP_READ, 8'd0, '0);
    push_cmd(OP_READ, 8'd3, '0);
    push_cmd(OP_READ, 8'd4, '0);
    push_cmd(OP_READ, 8'd255, '0);
    push_cmd(OP_REPLACE, 8'd4, 32'h1234_5678);
    push_cmd(OP_REPLACE, 8'd1, 32'h5a5a_a5a5);
    push_cmd(OP_READ, 8'd1, '0);
    push_cmd(OP_DELETE, 8'd0, '0);
    push_cmd(OP_DELETE, 8'd3, '0);
    push_cmd(OP_UNUSED, 8'd0, VAL_ONES);
    push_cmd(OP_DEL_LAST, 8'd128, '0);
    push_cmd(OP_CLEAR, 8'd255, VAL_ONES);
    push_cmd(OP_READ, 8'd0, '0);
    push_cmd(OP_DEL_LAST, 8'd0, '0);
    push_cmd(OP_APPEND, 8'd0, 32'h0000_0001);

    // Random bursts that drive the length up, down and into the full list
    burst_idx = 0;
    while (queued_count < TOTAL_CMDS) begin
      if (burst_idx == 0 || $urandom_range(0, 9) == 0) kind = BURST_FILL;
      else kind = burst_t'($urandom_range(0, 3));
      burst_len = $urandom_range(8, 40);
      case (kind)
        BURST_FILL: begin
          while (gen_len < DEPTH) begin
            if ($urandom_range(0, 1) == 0) push_cmd(OP_APPEND, pick_pos(gen_len), pick_value());
            else push_cmd(OP_INSERT, pick_pos(gen_len + 1), pick_value());
          end
          // Full beats a bad position
          push_cmd(OP_INSERT, 8'd255, pick_value());
          push_cmd(OP_INSERT, pick_pos(DEPTH + 1), pick_value());
          push_cmd(OP_APPEND, pick_pos(DEPTH), pick_value());
          push_cmd(OP_READ, 8'(DEPTH - 1), '0);
          push_cmd(OP_READ, 8'(DEPTH), '0);
          push_cmd(OP_REPLACE, 8'(DEPTH - 1), pick_value());
          push_cmd(OP_DELETE, pick_pos(DEPTH), '0);
        end
        BURST_NOISE: begin
          repeat (burst_len)
            push_cmd(OP_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 255)), $urandom);
        end
        default: begin
          repeat (burst_len) begin
            r = $urandom_range(99);
            case (kind)
              BURST_GROW:
                op = (r < 55) ? OP_INSERT : (r < 85) ? OP_APPEND :
                     (r < 93) ? OP_READ : OP_DELETE;
              BURST_SHRINK:
                op = (r < 50) ? OP_DELETE : (r < 80) ? OP_DEL_LAST :
                     (r < 90) ? OP_READ : OP_INSERT;
              default:
                op = (r < 2) ? OP_CLEAR : (r < 3) ? OP_UNUSED :
                     OP_W'($urandom_range(0, 5));
            endcase
            pos = (op == OP_INSERT) ? pick_pos(gen_len + 1) : pick_pos(gen_len);
            push_cmd(op, pos, pick_value());
          end
        end
      endcase
      burst_idx++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Every command returns exactly one result
    while (rsp_count < queued_count) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && predicted_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
